/* src/rea_pkg.sv */
// Package for the modulo 2^k element-wise ALU.
// Holds the opcode type, the ring width constants and the result record.
// Depends on nothing; every file of the block but the cfg channel interface uses it.
package rea_pkg;

	localparam int MAX_WIDTH = 64;
	localparam int HALF_W    = 32;
	localparam int FUNC_W    = 4;
	localparam int POS_W     = 7;

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD     = 4'd0,
		FN_SUB     = 4'd1,
		FN_MUL     = 4'd2,
		FN_NEG     = 4'd3,
		FN_NOT     = 4'd4,
		FN_AND     = 4'd5,
		FN_XOR     = 4'd6,
		FN_EQUAL   = 4'd7,
		FN_ARSHIFT = 4'd8,
		FN_RSHIFT  = 4'd9,
		FN_LSHIFT  = 4'd10,
		FN_BITREV  = 4'd11,
		FN_BITMASK = 4'd12
	} func_t;

	typedef struct packed {
		logic [MAX_WIDTH-1:0] value;
		logic                 range_error;
	} res_t;

endpackage

/* src/rea_req_if.sv */
// Request channel of the ALU: valid, ready and one input item.
// Depends on rea_pkg for the field widths.
interface rea_req_if;
	logic                              valid;
	logic                              ready;
	logic [rea_pkg::FUNC_W-1:0]        func;
	logic [rea_pkg::MAX_WIDTH-1:0]     operand_a;
	logic [rea_pkg::MAX_WIDTH-1:0]     operand_b;
	logic [rea_pkg::POS_W-1:0]         shift_amount;
	logic [rea_pkg::POS_W-1:0]         range_start;
	logic [rea_pkg::POS_W-1:0]         range_end;

	modport source (output valid, func, operand_a, operand_b, shift_amount,
		range_start, range_end, input ready);
	modport sink (input valid, func, operand_a, operand_b, shift_amount,
		range_start, range_end, output ready);
endinterface

/* src/rea_rsp_if.sv */
// Response channel of the ALU: valid, ready and one result item.
// Depends on rea_pkg for the field widths.
interface rea_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [rea_pkg::MAX_WIDTH-1:0] result_value;
	logic                          range_error;

	modport source (output valid, result_value, range_error, input ready);
	modport sink (input valid, result_value, range_error, output ready);
endinterface

/* src/rea_cfg_if.sv */
// Configuration write channel of the ALU, carrying the ring mode bit.
// Depends on nothing.
interface rea_cfg_if;
	logic valid;
	logic ready;
	logic ring_mode;

	modport source (output valid, ring_mode, input ready);
	modport sink (input valid, ring_mode, output ready);
endinterface

/* src/rea_mul.sv */
// Low half of a 64 by 64 bit product, built from three 32 by 32 bit products
// that are registered before the final sum. Depends on rea_pkg.
module rea_mul (
	input  logic                          clk,
	input  logic                          en,
	input  logic [rea_pkg::MAX_WIDTH-1:0] a,
	input  logic [rea_pkg::MAX_WIDTH-1:0] b,
	output logic [rea_pkg::MAX_WIDTH-1:0] prod
);
	localparam int H = rea_pkg::HALF_W;

	logic [2*H-1:0] p_ll_s2;
	logic [H-1:0]   p_lh_s2;
	logic [H-1:0]   p_hl_s2;
	logic [H-1:0]   cross_sum;

	always_ff @(posedge clk) begin
		if (en) begin
			p_ll_s2 <= (2*H)'(a[H-1:0]) * (2*H)'(b[H-1:0]);
			p_lh_s2 <= H'(a[H-1:0] * b[2*H-1:H]);
			p_hl_s2 <= H'(a[2*H-1:H] * b[H-1:0]);
		end
	end

	assign cross_sum = p_lh_s2 + p_hl_s2;
	assign prod      = p_ll_s2 + {cross_sum, {H{1'b0}}};
endmodule

/* src/rea_ops.sv */
// Combinational datapath for every operation apart from multiplication:
// arithmetic, logic, compare, shifts, bit reversal and bit mask over a range.
// Depends on rea_pkg.
module rea_ops (
	input  rea_pkg::func_t                func,
	input  logic                          ring_mode,
	input  logic [rea_pkg::MAX_WIDTH-1:0] a,
	input  logic [rea_pkg::MAX_WIDTH-1:0] b,
	input  logic [rea_pkg::POS_W-1:0]     shift_amount,
	input  logic [rea_pkg::POS_W-1:0]     range_start,
	input  logic [rea_pkg::POS_W-1:0]     range_end,
	output rea_pkg::res_t                 res
);
	localparam int W  = rea_pkg::MAX_WIDTH;
	localparam int H  = rea_pkg::HALF_W;
	localparam int SW = $clog2(W);
	localparam int PW = rea_pkg::POS_W;

	logic [W-1:0]    km;
	logic [PW-1:0]   k;
	logic            sign;
	logic [W-1:0]    ax;
	logic            s_big;
	logic [SW-1:0]   sh;
	logic [W-1:0]    asr;
	logic            bad;
	logic [W-1:0]    rev;
	logic [PW:0]     t;
	logic [W-1:0]    rev_al;
	logic [W-1:0]    mask_lo;
	logic [W-1:0]    mask_hi;
	logic [W-1:0]    rmask;
	logic [W-1:0]    bitrev;
	logic [W-1:0]    r;
	logic            err;

	assign km    = ring_mode ? {W{1'b1}} : {{(W-H){1'b0}}, {H{1'b1}}};
	assign k     = ring_mode ? PW'(W) : PW'(H);
	assign sign  = ring_mode ? a[W-1] : a[H-1];
	assign ax    = ring_mode ? a : {{(W-H){a[H-1]}}, a[H-1:0]};
	assign s_big = shift_amount >= k;
	assign sh    = shift_amount[SW-1:0];
	assign asr   = s_big ? {W{sign}} : W'($signed(ax) >>> sh);
	assign bad   = (range_start >= range_end) || (range_end > k);

	always_comb begin
		for (int i = 0; i < W; i++) begin
			rev[i] = a[W-1-i];
		end
	end

	// Align the fully reversed word so that the range maps onto itself.
	assign t = {1'b0, range_start} + {1'b0, range_end};
	always_comb begin
		if (t <= (PW+1)'(W)) begin
			rev_al = rev >> SW'((PW+1)'(W) - t);
		end else begin
			rev_al = rev << SW'(t - (PW+1)'(W));
		end
	end

	assign mask_lo = {W{1'b1}} << range_start[SW-1:0];
	assign mask_hi = (range_end >= PW'(W)) ? '0 : ({W{1'b1}} << range_end[SW-1:0]);
	assign rmask   = mask_lo & ~mask_hi;
	assign bitrev  = (a & ~rmask) | (rev_al & rmask);

	always_comb begin
		r   = '0;
		err = 1'b0;
		case (func)
			rea_pkg::FN_ADD: begin
				r = a + b;
			end
			rea_pkg::FN_SUB: begin
				r = a - b;
			end
			rea_pkg::FN_NEG: begin
				r = '0 - a;
			end
			rea_pkg::FN_NOT: begin
				r = ~a;
			end
			rea_pkg::FN_AND: begin
				r = a & b;
			end
			rea_pkg::FN_XOR: begin
				r = a ^ b;
			end
			rea_pkg::FN_EQUAL: begin
				r = W'(a == b);
			end
			rea_pkg::FN_ARSHIFT: begin
				r = asr;
			end
			rea_pkg::FN_RSHIFT: begin
				r = s_big ? '0 : (a >> sh);
			end
			rea_pkg::FN_LSHIFT: begin
				r = s_big ? '0 : (a << sh);
			end
			rea_pkg::FN_BITREV: begin
				err = bad;
				r   = bad ? a : bitrev;
			end
			rea_pkg::FN_BITMASK: begin
				err = bad;
				r   = bad ? '0 : (a & rmask);
			end
			default: begin
				r = '0;
			end
		endcase
	end

	assign res.value       = r & km;
	assign res.range_error = err;
endmodule

/* src/ring_elementwise_alu.sv */
// Top level of the element-wise ALU over the integers modulo 2^k.
// Instantiates rea_ops and rea_mul; uses rea_pkg and the channel interfaces.
//
// Usage: items enter on the req channel and results leave on the rsp channel,
// each moved by a transfer when valid and ready are both high. Every item
// gives exactly one result, in order. The cfg channel writes the ring mode
// (0 for a 32-bit ring, 1 for a 64-bit ring); it is always ready and should
// only be written while no item is in flight.
//
// From the request transfer to the earliest result transfer an item passes an
// input register, a stage holding the operation results and the three 32 by
// 32 bit partial products of the multiplier, and a result register where the
// partial products are summed. One item is taken per cycle for as long as the
// receiver takes results.
//
// Reset clears the pipeline and sets the ring mode to 64 bits. When the
// receiver stalls, the whole pipeline holds and req.ready falls while the
// result register is full.
module ring_elementwise_alu (
	input logic       clk,
	input logic       arst_n,
	rea_req_if.sink   req,
	rea_rsp_if.source rsp,
	rea_cfg_if.sink   cfg
);
	localparam int W  = rea_pkg::MAX_WIDTH;
	localparam int H  = rea_pkg::HALF_W;
	localparam int PW = rea_pkg::POS_W;

	logic            mode_q;
	logic            adv;
	logic            valid_s1;
	logic            valid_s2;
	logic            valid_s3;
	rea_pkg::func_t  func_s1;
	logic [W-1:0]    a_s1;
	logic [W-1:0]    b_s1;
	logic [PW-1:0]   shift_s1;
	logic [PW-1:0]   start_s1;
	logic [PW-1:0]   end_s1;
	logic [W-1:0]    km;
	logic [W-1:0]    am;
	logic [W-1:0]    bm;
	rea_pkg::res_t   ops_res;
	rea_pkg::res_t   res_s2;
	rea_pkg::func_t  func_s2;
	logic [W-1:0]    prod;
	rea_pkg::res_t   res_s3;

	assign adv       = !valid_s3 || rsp.ready;
	assign req.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b1;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (cfg.valid) begin
				mode_q <= cfg.ring_mode;
			end
			if (adv) begin
				valid_s1 <= req.valid;
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1  <= rea_pkg::func_t'(req.func);
			a_s1     <= req.operand_a;
			b_s1     <= req.operand_b;
			shift_s1 <= req.shift_amount;
			start_s1 <= req.range_start;
			end_s1   <= req.range_end;
		end
	end

	assign km = mode_q ? {W{1'b1}} : {{(W-H){1'b0}}, {H{1'b1}}};
	assign am = a_s1 & km;
	assign bm = b_s1 & km;

	rea_ops u_ops (
		.func         (func_s1),
		.ring_mode    (mode_q),
		.a            (am),
		.b            (bm),
		.shift_amount (shift_s1),
		.range_start  (start_s1),
		.range_end    (end_s1),
		.res          (ops_res)
	);

	rea_mul u_mul (
		.clk  (clk),
		.en   (adv),
		.a    (am),
		.b    (bm),
		.prod (prod)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2  <= ops_res;
			func_s2 <= func_s1;
			if (func_s2 == rea_pkg::FN_MUL) begin
				res_s3.value <= prod & km;
			end else begin
				res_s3.value <= res_s2.value;
			end
			res_s3.range_error <= res_s2.range_error;
		end
	end

	assign rsp.valid        = valid_s3;
	assign rsp.result_value = res_s3.value;
	assign rsp.range_error  = res_s3.range_error;
endmodule
